// ----- rtl/spsel_pkg.sv -----
`timescale 1ns / 1ps
package spsel_pkg;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 16;
	localparam int WIDTH_W = 11;
	localparam int CIDX_W  = 10;

	localparam logic [WIDTH_W-1:0] TOTAL_MAX = {WIDTH_W{1'b1}};

	typedef enum logic {
		REQ_SUBMIT = 1'b0,
		REQ_QUERY  = 1'b1
	} spsel_req_t;

	// outcome of one beat against the table entry it looked up
	typedef struct packed {
		logic wr_en;
		logic claim;
		logic demoted;
		logic is_pivot;
	} spsel_verdict_t;

endpackage

// ----- rtl/spsel_table.sv -----
`timescale 1ns / 1ps
module spsel_table #(
	parameter int MAX_COLS       = 1024,
	parameter int AW             = 10,
	parameter int EW             = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data,
	output logic [EW-1:0] entry,
	output logic          clearing
);
	import spsel_pkg::*;

	logic [EW-1:0] table_mem [MAX_COLS];
	logic [EW-1:0] rd_data_q;
	logic [EW-1:0] fwd_data_q;
	logic          fwd_hit_q;
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	// sweep after reset zeroes every entry, valid bit included
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(MAX_COLS - 1))
				clr_active_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q)
			table_mem[clr_addr_q] <= '0;
		else if (wr_en)
			table_mem[wr_addr] <= wr_data;
	end

	// read returns old data when the write lands on the same edge, so keep the write aside
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= table_mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_hit_q <= 1'b0;
		else if (rd_en)
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
	end

	assign entry    = fwd_hit_q ? fwd_data_q : rd_data_q;
	assign clearing = clr_active_q;

endmodule

// ----- rtl/spsel_decide.sv -----
`timescale 1ns / 1ps
module spsel_decide #(
	parameter int ROW_INDEX_BITS = 16
) (
	input  spsel_pkg::spsel_req_t              req,
	input  logic [spsel_pkg::ROW_W-1:0]        row,
	input  logic [spsel_pkg::WIDTH_W-1:0]      width,
	input  logic                               in_range,
	input  logic                               ent_valid,
	input  logic [ROW_INDEX_BITS-1:0]          ent_row,
	input  logic [spsel_pkg::WIDTH_W-1:0]      ent_width,
	output spsel_pkg::spsel_verdict_t          verdict,
	output logic [spsel_pkg::ROW_W-1:0]        demoted_row,
	output logic [spsel_pkg::ROW_W-1:0]        pivot_row
);
	import spsel_pkg::*;

	logic [ROW_W-1:0] row_masked;
	logic [ROW_W-1:0] ent_row16;

	assign row_masked = ROW_W'(ROW_INDEX_BITS'(row));
	assign ent_row16  = ROW_W'(ent_row);

	always_comb begin
		verdict     = '0;
		demoted_row = '0;
		pivot_row   = '0;
		if (req == REQ_SUBMIT) begin
			if (width == '0 || !in_range) begin
				verdict.demoted = 1'b1;
				demoted_row     = row_masked;
			end else if (!ent_valid) begin
				verdict.wr_en = 1'b1;
				verdict.claim = 1'b1;
			end else if (ent_width > width) begin
				// sparser row takes the column over
				verdict.wr_en   = 1'b1;
				verdict.demoted = 1'b1;
				demoted_row     = ent_row16;
			end else begin
				verdict.demoted = 1'b1;
				demoted_row     = row_masked;
			end
		end else begin
			verdict.is_pivot = in_range && ent_valid;
			if (in_range && ent_valid)
				pivot_row = ent_row16;
		end
	end

endmodule

// ----- rtl/sparsest_pivot_row_selector.sv -----
`timescale 1ns / 1ps
// sparsest pivot row selector
// command channel: a beat is taken on a rising edge with start high and busy low.
// req_type selects a row submit (row_index, leading_column, row_width) or a
// column query (column_index). every beat gives exactly one result.
// result channel: done is high for one cycle with the result fields; the
// receiver takes it on the edge that closes that cycle and cannot hold it off.
// a beat is registered in an input stage, its result in the output registers.
// throughput: one beat per cycle while busy is low; the column table is read
// one cycle and written the next, and a write to the column read in the same
// cycle is forwarded. reset: busy stays high while a sweep clears the table one
// column a cycle; pivot count and compact counters start at zero.
// queries should walk columns upwards; a query of column zero restarts both
// compact counters. pivot_count holds the pivot total after the latest beat.
module sparsest_pivot_row_selector #(
	parameter int MAX_COLS       = 1024,
	parameter int ROW_INDEX_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  spsel_pkg::spsel_req_t             req_type,
	input  logic [spsel_pkg::ROW_W-1:0]       row_index,
	input  logic [spsel_pkg::COL_W-1:0]       leading_column,
	input  logic [spsel_pkg::WIDTH_W-1:0]     row_width,
	input  logic [spsel_pkg::COL_W-1:0]       column_index,
	output logic                              done,
	output logic                              demoted_valid,
	output logic [spsel_pkg::ROW_W-1:0]       demoted_row,
	output logic [spsel_pkg::WIDTH_W-1:0]     pivot_count,
	output logic                              is_pivot_column,
	output logic [spsel_pkg::ROW_W-1:0]       pivot_row,
	output logic [spsel_pkg::CIDX_W-1:0]      compact_index
);
	import spsel_pkg::*;

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EW = 1 + ROW_INDEX_BITS + WIDTH_W;

	logic                 accept;
	logic [COL_W-1:0]     col_in;
	logic                 in_range_in;
	logic                 clearing;
	logic [EW-1:0]        entry;
	logic [EW-1:0]        wr_data;

	logic                 valid_s1;
	spsel_req_t           req_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [WIDTH_W-1:0]   width_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 in_range_s1;

	spsel_verdict_t       verdict;
	logic [ROW_W-1:0]     dem_row_c;
	logic [ROW_W-1:0]     piv_row_c;

	logic [WIDTH_W-1:0]   total_q;
	logic [CIDX_W-1:0]    pcnt_q;
	logic [CIDX_W-1:0]    npcnt_q;
	logic [CIDX_W-1:0]    pbase;
	logic [CIDX_W-1:0]    npbase;

	logic                 done_q;
	logic                 dem_valid_q;
	logic [ROW_W-1:0]     dem_row_q;
	logic                 is_piv_q;
	logic [ROW_W-1:0]     piv_row_q;
	logic [CIDX_W-1:0]    cidx_q;

	assign busy        = clearing;
	assign accept      = start && !busy;
	assign col_in      = (req_type == REQ_QUERY) ? column_index : leading_column;
	assign in_range_in = 32'(col_in) < 32'(MAX_COLS);

	assign wr_data = {1'b1, ROW_INDEX_BITS'(row_s1), width_s1};

	spsel_table #(
		.MAX_COLS       (MAX_COLS),
		.AW             (AW),
		.EW             (EW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && in_range_in),
		.rd_addr  (AW'(col_in)),
		.wr_en    (valid_s1 && verdict.wr_en),
		.wr_addr  (AW'(col_s1)),
		.wr_data  (wr_data),
		.entry    (entry),
		.clearing (clearing)
	);

	spsel_decide #(
		.ROW_INDEX_BITS (ROW_INDEX_BITS)
	) u_decide (
		.req         (req_s1),
		.row         (row_s1),
		.width       (width_s1),
		.in_range    (in_range_s1),
		.ent_valid   (entry[EW-1]),
		.ent_row     (entry[EW-2:WIDTH_W]),
		.ent_width   (entry[WIDTH_W-1:0]),
		.verdict     (verdict),
		.demoted_row (dem_row_c),
		.pivot_row   (piv_row_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req_type;
			row_s1      <= row_index;
			width_s1    <= row_width;
			col_s1      <= col_in;
			in_range_s1 <= in_range_in;
		end
	end

	// column zero restarts both running indices
	assign pbase  = (col_s1 == '0) ? '0 : pcnt_q;
	assign npbase = (col_s1 == '0) ? '0 : npcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pcnt_q  <= '0;
			npcnt_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1 && verdict.claim && total_q != TOTAL_MAX)
				total_q <= total_q + 1'b1;
			if (valid_s1 && req_s1 == REQ_QUERY) begin
				pcnt_q  <= verdict.is_pivot ? pbase + 1'b1 : pbase;
				npcnt_q <= verdict.is_pivot ? npbase : npbase + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dem_valid_q <= verdict.demoted;
			dem_row_q   <= dem_row_c;
			is_piv_q    <= verdict.is_pivot;
			piv_row_q   <= piv_row_c;
			if (req_s1 == REQ_QUERY)
				cidx_q <= verdict.is_pivot ? pbase : npbase;
			else
				cidx_q <= '0;
		end
	end

	assign done            = done_q;
	assign demoted_valid   = dem_valid_q;
	assign demoted_row     = dem_row_q;
	assign pivot_count     = total_q;
	assign is_pivot_column = is_piv_q;
	assign pivot_row       = piv_row_q;
	assign compact_index   = cidx_q;

endmodule

// ----- rtl/spsel_checker.sv -----
`timescale 1ns / 1ps
module spsel_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          done,
	input  logic                          demoted_valid,
	input  logic                          is_pivot_column,
	input  logic [spsel_pkg::WIDTH_W-1:0] pivot_count
);
	import spsel_pkg::*;

	// every accepted beat yields its result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted beat gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted beat");

	// a submit never reports a pivot column and a query never demotes
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(demoted_valid && is_pivot_column))
		else $error("result mixes submit and query fields");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		pivot_count >= $past(pivot_count))
		else $error("pivot count went down");

endmodule

bind sparsest_pivot_row_selector spsel_checker u_spsel_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.demoted_valid   (demoted_valid),
	.is_pivot_column (is_pivot_column),
	.pivot_count     (pivot_count)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import spsel_pkg::*;

	localparam int NUM_COLS       = 1024;
	localparam int STALL_LIMIT    = 4000;
	localparam int TARGET_BEATS   = 1700;
	localparam int WRAP_QUERIES   = 1040;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		logic               dem_valid;
		logic [ROW_W-1:0]   dem_row;
		logic [WIDTH_W-1:0] total;
		logic               is_piv;
		logic [ROW_W-1:0]   prow;
		logic [CIDX_W-1:0]  cidx;
	} sel_result_t;

	// mirror of the column table, predicts one result per beat
	class pivot_table_tracker;
		bit                 pivot_set [NUM_COLS];
		logic [ROW_W-1:0]   row_of    [NUM_COLS];
		logic [WIDTH_W-1:0] width_of  [NUM_COLS];
		logic [WIDTH_W-1:0] total;
		logic [CIDX_W-1:0]  piv_ctr;
		logic [CIDX_W-1:0]  free_ctr;
		sel_result_t        pending_results [$];
		int                 errors;
		int                 n_submits;
		int                 n_queries;
		int                 n_claims;
		int                 n_replaced;
		int                 n_refused;
		int                 n_piv_hits;

		function new();
			foreach (pivot_set[i]) pivot_set[i] = 1'b0;
			total      = '0;
			piv_ctr    = '0;
			free_ctr   = '0;
			errors     = 0;
			n_submits  = 0;
			n_queries  = 0;
			n_claims   = 0;
			n_replaced = 0;
			n_refused  = 0;
			n_piv_hits = 0;
		endfunction

		function void note_beat(spsel_req_t req, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] lead, logic [WIDTH_W-1:0] width, logic [COL_W-1:0] col);
			sel_result_t r;
			r = '0;
			if (req == REQ_SUBMIT) begin
				n_submits++;
				if (width == '0) begin
					r.dem_valid = 1'b1;
					r.dem_row   = row;
					n_refused++;
				end else if (!pivot_set[lead]) begin
					pivot_set[lead] = 1'b1;
					row_of[lead]    = row;
					width_of[lead]  = width;
					if (total != TOTAL_MAX)
						total++;
					n_claims++;
				end else if (width_of[lead] > width) begin
					// strictly sparser row takes over, the old one drops out
					r.dem_valid    = 1'b1;
					r.dem_row      = row_of[lead];
					row_of[lead]   = row;
					width_of[lead] = width;
					n_replaced++;
				end else begin
					r.dem_valid = 1'b1;
					r.dem_row   = row;
					n_refused++;
				end
			end else begin
				n_queries++;
				if (col == '0) begin
					piv_ctr  = '0;
					free_ctr = '0;
				end
				if (pivot_set[col]) begin
					r.is_piv = 1'b1;
					r.prow   = row_of[col];
					r.cidx   = piv_ctr;
					piv_ctr++;
					n_piv_hits++;
				end else begin
					r.cidx = free_ctr;
					free_ctr++;
				end
			end
			r.total = total;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string fname, logic [31:0] e, logic [31:0] a);
			if (a !== e) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, e, a);
			end
		endfunction

		function void check_result(sel_result_t got);
			sel_result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing outstanding, expected none, got %h",
					$time, got);
				return;
			end
			e = pending_results.pop_front();
			compare_field("demoted_valid", 32'(e.dem_valid), 32'(got.dem_valid));
			compare_field("demoted_row", 32'(e.dem_row), 32'(got.dem_row));
			compare_field("pivot_count", 32'(e.total), 32'(got.total));
			compare_field("is_pivot_column", 32'(e.is_piv), 32'(got.is_piv));
			compare_field("pivot_row", 32'(e.prow), 32'(got.prow));
			compare_field("compact_index", 32'(e.cidx), 32'(got.cidx));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	spsel_req_t         req_type;
	logic [ROW_W-1:0]   row_index;
	logic [COL_W-1:0]   leading_column;
	logic [WIDTH_W-1:0] row_width;
	logic [COL_W-1:0]   column_index;
	logic               done;
	logic               demoted_valid;
	logic [ROW_W-1:0]   demoted_row;
	logic [WIDTH_W-1:0] pivot_count;
	logic               is_pivot_column;
	logic [ROW_W-1:0]   pivot_row;
	logic [CIDX_W-1:0]  compact_index;

	pivot_table_tracker tracker = new();
	bit steady_feed;
	int beats_sent;
	int stall_cycles;

	sparsest_pivot_row_selector uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.row_index       (row_index),
		.leading_column  (leading_column),
		.row_width       (row_width),
		.column_index    (column_index),
		.done            (done),
		.demoted_valid   (demoted_valid),
		.demoted_row     (demoted_row),
		.pivot_count     (pivot_count),
		.is_pivot_column (is_pivot_column),
		.pivot_row       (pivot_row),
		.compact_index   (compact_index)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			tracker.check_result({demoted_valid, demoted_row, pivot_count,
				is_pivot_column, pivot_row, compact_index});
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("[sparsest_pivot_row_selector] ERROR");
		$finish;
	end

	task automatic drive_beat(spsel_req_t req, logic [ROW_W-1:0] row, logic [COL_W-1:0] lead,
			logic [WIDTH_W-1:0] width, logic [COL_W-1:0] col);
		while (!steady_feed && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start          <= 1'b1;
		req_type       <= req;
		row_index      <= row;
		leading_column <= lead;
		row_width      <= width;
		column_index   <= col;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tracker.note_beat(req, row, lead, width, col);
		beats_sent++;
	endtask

	task automatic submit_row(logic [ROW_W-1:0] row, logic [COL_W-1:0] lead,
			logic [WIDTH_W-1:0] width);
		drive_beat(REQ_SUBMIT, row, lead, width, COL_W'($urandom));
	endtask

	task automatic query_column(logic [COL_W-1:0] col);
		drive_beat(REQ_QUERY, ROW_W'($urandom), COL_W'($urandom), WIDTH_W'($urandom), col);
	endtask

	// mostly narrow widths so that ties and takeovers happen often
	function automatic logic [WIDTH_W-1:0] pick_width();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: pick_width = '0;
			1: pick_width = WIDTH_W'(NUM_COLS);
			2, 3, 4: pick_width = WIDTH_W'($urandom_range(1, 4));
			5, 6: pick_width = WIDTH_W'($urandom_range(1, 32));
			default: pick_width = WIDTH_W'($urandom_range(1, NUM_COLS));
		endcase
	endfunction

	// rows aimed at a window of columns, then a walk over that window; noisy rounds add stray queries and empty rows
	task automatic run_round(bit noisy);
		int unsigned base;
		int unsigned span;
		int unsigned col;
		base = $urandom_range(0, NUM_COLS - 1);
		span = $urandom_range(1, 96);
		repeat ($urandom_range(6, 40))
			submit_row(ROW_W'($urandom), COL_W'(base + $urandom_range(0, span - 1)), pick_width());
		if (!noisy || $urandom_range(0, 1) == 0)
			query_column('0);
		col = base;
		while (col < NUM_COLS && col < base + span) begin
			query_column(COL_W'(col));
			col += $urandom_range(1, 3);
		end
		if (noisy) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 1) == 0)
					query_column(COL_W'($urandom_range(0, NUM_COLS - 1)));
				else
					submit_row(ROW_W'($urandom), COL_W'($urandom), '0);
			end
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		req_type       = REQ_SUBMIT;
		row_index      = '0;
		leading_column = '0;
		row_width      = '0;
		column_index   = '0;
		steady_feed    = 1'b0;
		beats_sent     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: claims, tie, takeover, empty row, wider row, field extremes
		submit_row(16'h0000, 10'd0, 11'd1);
		submit_row(16'hffff, 10'h3ff, 11'd1024);
		submit_row(16'h1234, 10'h3ff, 11'd1024);
		submit_row(16'habcd, 10'h3ff, 11'd1023);
		submit_row(16'h5555, 10'd0, 11'd0);
		submit_row(16'haaaa, 10'd0, 11'd2);
		submit_row(16'h8000, 10'h155, 11'h2aa);
		submit_row(16'h7fff, 10'h2aa, 11'h555);
		submit_row(16'h0001, 10'h155, 11'd1);
		submit_row(16'h00ff, 10'h200, 11'h7ff);
		query_column(10'd0);
		query_column(10'd1);
		query_column(10'h155);
		query_column(10'h2aa);
		query_column(10'h3ff);
		query_column(10'd5);
		query_column(10'h200);
		query_column(10'd0);
		query_column(10'h3ff);

		// long walk without a restart so the free-column counter wraps
		steady_feed = 1'b1;
		query_column(10'd0);
		repeat (WRAP_QUERIES)
			query_column(COL_W'($urandom_range(1, NUM_COLS - 1)));
		steady_feed = 1'b0;

		while (beats_sent < TARGET_BEATS)
			run_round($urandom_range(0, 4) == 0);
		start <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d row submits: %0d claims, %0d takeovers, %0d refused rows",
			tracker.n_submits, tracker.n_claims, tracker.n_replaced, tracker.n_refused);
		$display("and %0d column queries, %0d of them on pivot columns",
			tracker.n_queries, tracker.n_piv_hits);
		if (tracker.errors == 0)
			$display("[sparsest_pivot_row_selector] OK");
		else
			$display("[sparsest_pivot_row_selector] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/spsel_pkg.sv
rtl/spsel_table.sv
rtl/spsel_decide.sv
rtl/sparsest_pivot_row_selector.sv
rtl/spsel_checker.sv
verif/tb_top.sv
